// ===== design/prat_pkg.sv =====
// shared types and constants for the port range allocation table
`timescale 1ns / 1ps
`default_nettype none

package prat_pkg;

  typedef enum logic {
    OP_REG   = 1'b0,
    OP_UNREG = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_INVAL = 2'd1,
    STAT_BUSY  = 2'd2,
    STAT_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_DONE
  } state_e;

  // result of one compare of the request against one stored entry
  typedef struct packed {
    logic overlap;
    logic match;
  } cmp_res_t;

  localparam int unsigned START_W = 16;
  localparam int unsigned COUNT_W = 17;
  localparam int unsigned END_W   = 18;

  // reserved ranges loaded at reset
  localparam int unsigned RSV_N = 3;
  localparam logic [START_W-1:0] RSV_START [RSV_N] = '{16'h0020, 16'h00A0, 16'h00F8};
  localparam logic [COUNT_W-1:0] RSV_LEN   [RSV_N] = '{17'd32, 17'd32, 17'd16};

endpackage

`default_nettype wire

// ===== design/port_range_allocation_table.sv =====
// port range allocation table: register and unregister port ranges
//
// channel  dir  tdata (low bit up)                         tuser
// s_axis   in   start_port[15:0], port_count[32:16], pad   operation
// m_axis   out  status[1:0], pad                            -
//
// a request sweeps the table one entry per cycle through the single read port
// of the entry ram and the one shared compare unit before its result is pending;
// the input is ready again once the result is in the output register.
// reset loads the three reserved ranges at once; no clearing pass.
// the result waits in an output register; a stalled output holds the next
// result in its final state until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none

module port_range_allocation_table
  import prat_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned PORT_SPACE    = 65536
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // start_port, port_count, zero pad
  input  wire logic        s_axis_tuser,  // operation
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata   // status, zero pad
);

  localparam int unsigned IdxW  = $clog2(TABLE_ENTRIES);
  localparam int unsigned EntW  = START_W + COUNT_W;
  localparam logic [IdxW-1:0]  LastIdx = IdxW'(TABLE_ENTRIES - 1);
  localparam logic [END_W-1:0] SpaceW  = END_W'(PORT_SPACE);

  state_e state_q, state_d;

  logic                     op_q;
  logic [START_W-1:0]       start_q;
  logic [COUNT_W-1:0]       count_q;
  logic [END_W-1:0]         req_end;

  logic [IdxW-1:0]          cnt_q, cnt_d;
  logic                     pv_q, pv_d;
  logic [IdxW-1:0]          pidx_q;

  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [RSV_N-1:0]         rsv_live_q, rsv_live_d;

  logic                     hit_q, found_q, free_q;
  logic [IdxW-1:0]          mt_idx_q, free_idx_q;

  logic                     out_valid_q, out_valid_d;
  status_e                  out_status_q, status_c;

  logic                     accept, out_free, done_fire, wr_en;
  logic [EntW-1:0]          ram_rdata;
  logic [START_W-1:0]       ent_start;
  logic [COUNT_W-1:0]       ent_len;
  logic                     ent_valid;
  cmp_res_t                 cmp_res;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign done_fire = (state_q == S_DONE) && out_free;
  assign req_end   = END_W'(start_q) + END_W'(count_q);

  prat_ram #(
    .WIDTH (EntW),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (free_idx_q),
    .wdata_i ({count_q, start_q}),
    .re_i    (state_q == S_SCAN),
    .raddr_i (cnt_q),
    .rdata_o (ram_rdata)
  );

  // reserved entries read their reset contents until overwritten
  always_comb begin
    ent_start = ram_rdata[START_W-1:0];
    ent_len   = ram_rdata[EntW-1:START_W];
    for (int i = 0; i < RSV_N; i++) begin
      if (pidx_q == IdxW'(i) && rsv_live_q[i]) begin
        ent_start = RSV_START[i];
        ent_len   = RSV_LEN[i];
      end
    end
  end

  assign ent_valid = valid_q[pidx_q];

  prat_cmp u_cmp (
    .req_start_i (start_q),
    .req_end_i   (req_end),
    .ent_start_i (ent_start),
    .ent_len_i   (ent_len),
    .res_o       (cmp_res)
  );

  // final status
  always_comb begin
    if (op_q == OP_REG) begin
      priority if (req_end > SpaceW) begin
        status_c = STAT_INVAL;
      end else if (hit_q) begin
        status_c = STAT_BUSY;
      end else if (!free_q) begin
        status_c = STAT_FULL;
      end else begin
        status_c = STAT_OK;
      end
    end else begin
      status_c = found_q ? STAT_OK : STAT_INVAL;
    end
  end

  assign wr_en = done_fire && (op_q == OP_REG) && (status_c == STAT_OK);

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pv_d        = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    valid_d     = valid_q;
    rsv_live_d  = rsv_live_q;
    s_axis_tready = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        cnt_d = '0;
        if (s_axis_tvalid) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        pv_d  = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastIdx) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          if (wr_en) begin
            valid_d[free_idx_q] = 1'b1;
            for (int i = 0; i < RSV_N; i++) begin
              if (free_idx_q == IdxW'(i)) begin
                rsv_live_d[i] = 1'b0;
              end
            end
          end else if (op_q == OP_UNREG && found_q) begin
            valid_d[mt_idx_q] = 1'b0;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      valid_q     <= TABLE_ENTRIES'((1 << RSV_N) - 1);
      rsv_live_q  <= '1;
      hit_q       <= 1'b0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pv_q        <= pv_d;
      out_valid_q <= out_valid_d;
      valid_q     <= valid_d;
      rsv_live_q  <= rsv_live_d;
      if (accept) begin
        hit_q   <= 1'b0;
        found_q <= 1'b0;
        free_q  <= 1'b0;
      end else if (pv_q) begin
        if (ent_valid && cmp_res.overlap) begin
          hit_q <= 1'b1;
        end
        // lowest matching entry for unregister, lowest free entry for register
        if (ent_valid && cmp_res.match && !found_q) begin
          found_q <= 1'b1;
        end
        if (!ent_valid && !free_q) begin
          free_q <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= s_axis_tuser;
      start_q <= s_axis_tdata[15:0];
      count_q <= s_axis_tdata[32:16];
    end
    if (state_q == S_SCAN) begin
      pidx_q <= cnt_q;
    end
    if (pv_q && ent_valid && cmp_res.match && !found_q) begin
      mt_idx_q <= pidx_q;
    end
    if (pv_q && !ent_valid && !free_q) begin
      free_idx_q <= pidx_q;
    end
    if (done_fire) begin
      out_status_q <= status_c;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_status_q};

  // a result only appears out of the final state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_DONE))
    else $error("result without a finished request");

  // the chosen free entry really is free while the request is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && free_q) |-> !valid_q[free_idx_q])
    else $error("free entry is marked valid");

  // the matched entry for unregister is a live entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && found_q) |-> valid_q[mt_idx_q])
    else $error("unregister match on an invalid entry");

  // a successful register adds exactly one live entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> ($countones(valid_q) == $past($countones(valid_q)) + 1))
    else $error("register did not add one entry");

  // no request is taken while a result is still being built
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_WAIT) |-> !s_axis_tready)
    else $error("ready during table sweep");

endmodule

`default_nettype wire

// ===== design/prat_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module prat_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/prat_cmp.sv =====
// shared range compare unit: overlap and start match of request vs one entry
`timescale 1ns / 1ps
`default_nettype none

module prat_cmp
  import prat_pkg::*;
(
  input  wire logic [START_W-1:0] req_start_i,
  input  wire logic [END_W-1:0]   req_end_i,
  input  wire logic [START_W-1:0] ent_start_i,
  input  wire logic [COUNT_W-1:0] ent_len_i,
  output cmp_res_t                res_o
);

  logic [END_W-1:0] s_ext;
  logic [END_W-1:0] ns_ext;
  logic [END_W-1:0] ne;

  always_comb begin
    s_ext  = END_W'(req_start_i);
    ns_ext = END_W'(ent_start_i);
    ne     = ns_ext + END_W'(ent_len_i);
    // adjacent ranges do not conflict
    res_o.overlap = ((s_ext >= ns_ext) && (s_ext < ne)) ||
                    ((s_ext < ne) && (req_end_i > ns_ext));
    res_o.match   = (req_start_i == ent_start_i);
  end

endmodule

`default_nettype wire

// ===== verif/port_range_allocation_table_test.sv =====
// stream-level test of the port range allocation table against a table predictor
`timescale 1ns / 1ps

module port_range_allocation_table_test;
  import prat_pkg::*;

  localparam int unsigned TBL_N      = 16;
  localparam int unsigned PORT_LIMIT = 65536;
  localparam int unsigned RAND_ITEMS = 1320;
  localparam int unsigned CALM_ITEMS = 200;

  class range_table_scoreboard;
    bit                 live [TBL_N];
    logic [START_W-1:0] base [TBL_N];
    logic [COUNT_W-1:0] span [TBL_N];
    status_e            status_q[$];
    int                 errors;

    function new();
      for (int i = 0; i < TBL_N; i++) begin
        live[i] = 1'b0;
        base[i] = '0;
        span[i] = '0;
      end
      for (int i = 0; i < RSV_N; i++) begin
        live[i] = 1'b1;
        base[i] = RSV_START[i];
        span[i] = RSV_LEN[i];
      end
      errors = 0;
    endfunction

    function status_e claim_range(logic [START_W-1:0] s, logic [COUNT_W-1:0] c);
      logic [END_W-1:0] req_end;
      logic [END_W-1:0] ent_end;
      req_end = {2'b00, s} + {1'b0, c};
      if (req_end > PORT_LIMIT) return STAT_INVAL;
      for (int i = 0; i < TBL_N; i++) begin
        if (live[i]) begin
          ent_end = {2'b00, base[i]} + {1'b0, span[i]};
          if ((s >= base[i] && s < ent_end) || (s < ent_end && req_end > base[i]))
            return STAT_BUSY;
        end
      end
      // lowest free slot wins
      for (int i = 0; i < TBL_N; i++) begin
        if (!live[i]) begin
          live[i] = 1'b1;
          base[i] = s;
          span[i] = c;
          return STAT_OK;
        end
      end
      return STAT_FULL;
    endfunction

    function status_e release_range(logic [START_W-1:0] s);
      for (int i = 0; i < TBL_N; i++) begin
        if (live[i] && base[i] == s) begin
          live[i] = 1'b0;
          return STAT_OK;
        end
      end
      return STAT_INVAL;
    endfunction

    function void note_request(op_e op, logic [START_W-1:0] s, logic [COUNT_W-1:0] c);
      if (op == OP_REG) status_q.push_back(claim_range(s, c));
      else status_q.push_back(release_range(s));
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    function int live_count();
      int n;
      n = 0;
      for (int i = 0; i < TBL_N; i++) if (live[i]) n++;
      return n;
    endfunction

    // start of a random occupied entry, or a random port if the table is empty
    function logic [START_W-1:0] live_start();
      int idx;
      if (live_count() == 0) return START_W'($urandom);
      do idx = $urandom_range(0, TBL_N - 1); while (!live[idx]);
      return base[idx];
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_status(status_e got);
      status_e want;
      if (status_q.size() == 0) begin
        report_mismatch($sformatf("status %s with no request outstanding", got.name()));
      end else begin
        want = status_q.pop_front();
        if (got !== want)
          report_mismatch($sformatf("status %s, expected %s", got.name(), want.name()));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // start_port, port_count, zero pad
  logic        s_axis_tuser = 1'b0;  // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;  // status, zero pad

  range_table_scoreboard sb = new();
  bit calm = 1'b0;

  port_range_allocation_table DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_request(op_e op, logic [START_W-1:0] s, logic [COUNT_W-1:0] c);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {7'd0, c, s};
    s_axis_tuser  = op;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(op, s, c);
    @(negedge clk_i);
  endtask

  task automatic send_random_request();
    int pick;
    pick = $urandom_range(0, 99);
    // lean toward releases when the table is full so registrations keep landing
    if (sb.live_count() == TBL_N && pick < 50) pick = pick + 50;
    if (pick < 50)
      send_request(OP_REG, START_W'($urandom_range(0, 1023)),
                   COUNT_W'($urandom_range(0, 40)));
    else if (pick < 60)
      send_request(OP_REG, START_W'($urandom), COUNT_W'($urandom_range(0, PORT_LIMIT)));
    else if (pick < 90)
      send_request(OP_UNREG, sb.live_start(), COUNT_W'($urandom_range(0, PORT_LIMIT)));
    else
      send_request(OP_UNREG, START_W'($urandom), COUNT_W'($urandom_range(0, PORT_LIMIT)));
  endtask

  // output side: random stall bursts until the calm tail
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready = 1'b0;
        stall_left = $urandom_range(1, 6) - 1;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_status(status_e'(m_axis_tdata[1:0]));
  end

  initial begin
    #1000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: overlap edges, bounds, zero counts, duplicates, full table
    send_request(OP_REG, 16'h0020, 17'd1);        // inside a reserved range
    send_request(OP_REG, 16'h0040, 17'd16);       // adjacent above
    send_request(OP_REG, 16'h0010, 17'd16);       // adjacent below
    send_request(OP_REG, 16'h009F, 17'd2);        // straddles a range start
    send_request(OP_REG, 16'hFFFF, 17'd1);        // ends exactly at the top
    send_request(OP_REG, 16'hFFFF, 17'd2);        // one past the top
    send_request(OP_REG, 16'h0000, 17'd65536);    // whole space, overlaps
    send_request(OP_REG, 16'h0001, 17'd65536);    // out of bounds
    send_request(OP_REG, 16'h0200, 17'd0);        // empty range
    send_request(OP_REG, 16'h0200, 17'd0);        // same empty range again
    send_request(OP_UNREG, 16'h0200, 17'd0);
    send_request(OP_UNREG, 16'h0200, 17'd0);
    send_request(OP_UNREG, 16'h0200, 17'd0);      // nothing left to free
    send_request(OP_UNREG, 16'h1234, 17'd65536);  // no match, count ignored
    for (int i = 0; i < 10; i++)
      send_request(OP_REG, START_W'(16'h0400 + i * 16), 17'd8);
    send_request(OP_REG, 16'h0800, 17'd4);        // no free entry
    send_request(OP_REG, 16'h0020, 17'd4);        // overlap wins over full
    send_request(OP_REG, 16'hFFF0, 17'd32);       // bounds win over full
    send_request(OP_UNREG, 16'h0020, 17'd0);      // free a reserved range

    // hold the input back until the table has answered everything
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS - CALM_ITEMS) calm = 1'b1;
      send_random_request();
    end
    s_axis_tvalid = 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2 * TBL_N + 8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
